// ===== hdl/fsqc_pkg.sv =====
// shared types and constants for the fp32 square root block
package fsqc_pkg;

    localparam int RootBits = 24;
    localparam int RemBits  = 26;
    localparam int RadBits  = 48;

    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
    localparam logic [31:0] POS_INF   = 32'h7F80_0000;
    localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;

    // payload carried down the root pipeline
    typedef struct packed {
        logic                special;
        logic [31:0]         special_val;
        logic [7:0]          biased;
        logic [RadBits-1:0]  radicand;
        logic [RootBits-1:0] root;
        logic [RemBits-1:0]  rem;
    } fsqc_item_t;

endpackage

// ===== hdl/fp32_sqrt_clamp_negative.sv =====
// fp32 square root with negative inputs other than -0 and NaNs clamped to +0
// pipeline: decode register, 6 root stage registers, then round into the output register
// throughput: one transfer per cycle while the output is not stalled; six 4-bit restoring root stages set the depth
// a stall freezes the whole pipeline; results still wait in the output register
// reset clears only the valid bits, the data registers are not reset
module fp32_sqrt_clamp_negative
    import fsqc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // root_bits
);

    localparam int Stages = 6;

    logic       advance;
    logic       dec_valid_reg;
    fsqc_item_t dec_item_reg;
    fsqc_item_t dec_item_next;
    logic       out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;

    logic       st_valid [Stages+1];
    fsqc_item_t st_item  [Stages+1];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // decode: specials, subnormal normalize, exponent parity
    always_comb
    begin
        logic        sign;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [23:0] m;
        logic [4:0]  lz;
        logic signed [9:0] e;
        sign = s_tdata[31];
        ex   = s_tdata[30:23];
        frac = s_tdata[22:0];
        lz   = 5'd0;
        for (int i = 22; i >= 0; i--)
        begin
            if (frac[i] && lz == 5'd0 && frac[22:0] >> (i + 1) == 23'd0)
            begin
                lz = 5'(23 - i);
            end
        end
        if (ex == 8'd0)
        begin
            m = {1'b0, frac} << lz;
            e = 10'sd1 - $signed({5'd0, lz});
        end
        else
        begin
            m = {1'b1, frac};
            e = $signed({2'b00, ex});
        end
        dec_item_next = '0;
        if (!e[0])
        begin
            dec_item_next.radicand = {23'd0, m, 1'b0} << 23;
            e = e - 10'sd1;
        end
        else
        begin
            dec_item_next.radicand = {24'd0, m} << 23;
        end
        dec_item_next.biased = 8'((e + 10'sd127) >>> 1);
        dec_item_next.special = 1'b1;
        if (ex == 8'hFF && frac != 23'd0)
            dec_item_next.special_val = s_tdata | QUIET_BIT;
        else if (s_tdata == NEG_ZERO)
            dec_item_next.special_val = NEG_ZERO;
        else if (sign || s_tdata == 32'd0)
            dec_item_next.special_val = 32'd0;
        else if (ex == 8'hFF)
            dec_item_next.special_val = POS_INF;
        else
            dec_item_next.special = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            dec_valid_reg <= s_tvalid;
            out_valid_reg <= st_valid[Stages];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dec_item_reg <= dec_item_next;
            out_data_reg <= out_data_next;
        end
    end

    assign st_valid[0] = dec_valid_reg;
    assign st_item[0]  = dec_item_reg;

    for (genvar g = 0; g < Stages; g++)
    begin : g_root
        fsqc_root_stage #(
            .BITS  (4),
            .FIRST (23 - 4 * g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (st_valid[g]),
            .in_item   (st_item[g]),
            .out_valid (st_valid[g+1]),
            .out_item  (st_item[g+1])
        );
    end

    // round: specials pass through; no ties possible, round up when remainder exceeds root
    always_comb
    begin
        fsqc_item_t it;
        logic [31:0] base;
        it   = st_item[Stages];
        base = {1'b0, it.biased, it.root[22:0]};
        if (it.special)
            out_data_next = it.special_val;
        else if (it.rem > {2'b00, it.root})
            out_data_next = base + 32'd1;
        else
            out_data_next = base;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(dec_valid_reg) && $stable(st_valid[Stages]))
        else $error("pipeline moved during stall");
    a_norm_root: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid[Stages] && !st_item[Stages].special |-> st_item[Stages].root[23])
        else $error("root lost its leading bit");
`endif

endmodule

// ===== hdl/fsqc_root_stage.sv =====
// one pipeline stage of the restoring square root: a group of root bits per stage
module fsqc_root_stage
    import fsqc_pkg::*;
#(
    parameter int BITS  = 4,
    parameter int FIRST = 23
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       in_valid,
    input  fsqc_item_t in_item,
    output logic       out_valid,
    output fsqc_item_t out_item
);

    fsqc_item_t item_next;
    fsqc_item_t item_reg;
    logic       valid_reg;

    always_comb
    begin
        logic [RemBits-1:0]  rem;
        logic [RemBits-1:0]  trial;
        logic [RootBits-1:0] root;
        logic [1:0]          pair;
        item_next = in_item;
        rem  = in_item.rem;
        root = in_item.root;
        for (int k = 0; k < BITS; k++)
        begin
            pair  = in_item.radicand[2*(FIRST-k) +: 2];
            rem   = {rem[RemBits-3:0], pair};
            trial = {root[RootBits-1:0], 2'b01};
            root  = {root[RootBits-2:0], 1'b0};
            if (rem >= trial)
            begin
                rem     = rem - trial;
                root[0] = 1'b1;
            end
        end
        item_next.rem  = rem;
        item_next.root = root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== tb/fp32_sqrt_clamp_negative_checker.sv =====
// checker for the fp32 square root block: predicts each root and compares results
module fp32_sqrt_clamp_negative_checker
    import fsqc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          roots_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] root_queue[$];
    int mismatches = 0;
    int extra = 0;

    // specials, then a bitwise restoring square root of a 48-bit radicand, then rounding
    function automatic logic [31:0] predict_root(logic [31:0] x);
        logic [7:0]  ex;
        logic [22:0] frac;
        int          e;
        logic [47:0] m;
        logic [47:0] rad;
        logic [47:0] rem;
        logic [47:0] root;
        logic [47:0] trial;
        logic [31:0] res;
        ex = x[30:23];
        frac = x[22:0];
        if (ex == 8'hFF && frac != 0) return x | QUIET_BIT;
        if (x == NEG_ZERO) return NEG_ZERO;
        if (x[31]) return 32'h0;
        if (x == 32'h0) return 32'h0;
        if (ex == 8'hFF) return POS_INF;
        if (ex == 0)
        begin
            e = 1;
            m = 48'(frac);
            while (m[23] == 1'b0)
            begin
                m = m << 1;
                e = e - 1;
            end
        end
        else
        begin
            e = int'(ex);
            m = {24'h0, 1'b1, frac};
        end
        // unbiased exponent must be even
        if (((e + 32) % 2) == 0)
        begin
            m = m << 1;
            e = e - 1;
        end
        rad = m << 23;
        rem = 0;
        root = 0;
        for (int i = 23; i >= 0; i--)
        begin
            rem = (rem << 2) | ((rad >> (2 * i)) & 48'd3);
            trial = (root << 2) | 48'd1;
            root = root << 1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = root | 48'd1;
            end
        end
        res = (32'((e + 127) / 2) << 23) + (root[31:0] - 32'h0080_0000);
        if (rem > root) res = res + 1;
        return res;
    endfunction

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            roots_seen = 0;
        end
        else
        begin
            if (s_tvalid && s_tready) root_queue.push_back(predict_root(s_tdata));
            if (m_tvalid && m_tready)
            begin
                roots_seen++;
                if (root_queue.size() == 0)
                begin
                    extra++;
                    if (mismatches + extra <= 10)
                        $display("unexpected result root_bits=%h", m_tdata);
                end
                else
                begin
                    want = root_queue.pop_front();
                    if (want !== m_tdata)
                    begin
                        mismatches++;
                        if (mismatches + extra <= 10)
                            $display("root_bits mismatch: expected %h got %h",
                                     want, m_tdata);
                    end
                end
            end
        end
        pending = root_queue.size();
    end

    assign fail_count = mismatches + extra;
endmodule

// ===== tb/fp32_sqrt_clamp_negative_tb.sv =====
// top of the fp32 square root testbench: stimulus, stalls and verdict
module fp32_sqrt_clamp_negative_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'h0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    int          roots_seen;
    int          cycle = 0;
    int          sent = 0;
    logic        quiet_stretch = 1'b0;
    logic [31:0] directed[$];

    localparam int CycleLimit = 200000;

    always #6 clk = ~clk;

    fp32_sqrt_clamp_negative dut (.*);

    fp32_sqrt_clamp_negative_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CycleLimit)
        begin
            $display("timeout with %0d results pending", pending);
            $display("[fp32_sqrt_clamp_negative] ERROR");
            $finish;
        end
    end

    // receiver stalls, none during the quiet stretch
    always @(posedge clk)
        m_tready <= quiet_stretch || ($urandom_range(99) >= 17);

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:0] = {8'h00, 23'($urandom_range(15))};
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_operand(logic [31:0] v);
        while (!quiet_stretch && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    initial
    begin
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'hFFBF_FFFF, 32'h0000_0001,
                     32'h007F_FFFF, 32'h8000_0001, 32'h807F_FFFF, 32'h0080_0000,
                     32'h7F7F_FFFF, 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000,
                     32'hBF80_0000, 32'hFF7F_FFFF, 32'h3F7F_FFFF, 32'h0040_0000,
                     32'h7FFF_FFFF, 32'hFFFF_FFFF};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) send_operand(directed[i]);
        for (int n = 0; n < 1050; n++)
        begin
            quiet_stretch <= (n >= 400 && n < 550);
            send_operand(random_operand());
        end
        s_tvalid <= 1'b0;
        quiet_stretch <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d operands incl. zeros, infinities, nans, subnormals, negatives",
                 sent);
        $display("checked %0d roots under random stalls on both sides", roots_seen);
        if (fail_count == 0)
            $display("[fp32_sqrt_clamp_negative] OK");
        else
            $display("[fp32_sqrt_clamp_negative] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/fsqc_pkg.sv
hdl/fsqc_root_stage.sv
hdl/fp32_sqrt_clamp_negative.sv
tb/fp32_sqrt_clamp_negative_checker.sv
tb/fp32_sqrt_clamp_negative_tb.sv
